/* hdl/wsdf_pkg.sv */
// ----------------------------------------------------------------------------
// wsdf_pkg
// Shared types and constants for the WebSocket frame deframer.
// ----------------------------------------------------------------------------
package wsdf_pkg;

  // Default width of the frame length counter
  localparam int unsigned LENGTH_WIDTH_DEF = 64;

  // Result queue depth (power of two)
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Data opcodes
  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;

  // Length escape codes in the second header byte
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // One result transaction
  typedef struct packed {
    logic [7:0] data;
    logic       byte_valid;
    logic       frame_end;
    logic       message_end;
    logic [3:0] msg_type;
    logic       drop;
  } wsdf_res_t;

endpackage

/* hdl/wsdf_front.sv */
// ----------------------------------------------------------------------------
// wsdf_front
// Header parser and payload unmasker: one byte per accepted transaction,
// produces at most one result per byte.
// ----------------------------------------------------------------------------
module wsdf_front #(
  parameter int unsigned LENGTH_WIDTH = wsdf_pkg::LENGTH_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          byte_i,
  output logic                res_valid_o,
  output wsdf_pkg::wsdf_res_t res_o
);
  import wsdf_pkg::*;

  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_EXT  = 3'd2,
    PH_KEY  = 3'd3,
    PH_PAY  = 3'd4
  } phase_e;

  phase_e                  phase_q, phase_d;
  logic                    final_q, final_d;
  logic [3:0]              op_q, op_d;
  logic                    mask_q, mask_d;
  logic [LENGTH_WIDTH-1:0] len_q, len_d;
  logic [2:0]              cnt_q, cnt_d;
  logic                    long_q, long_d;
  logic [31:0]             key_q, key_d;
  logic [1:0]              pos_q, pos_d;

  logic       is_data;
  logic       after_len;
  logic       hdr_done;
  logic       pay_end;
  logic [7:0] key_byte;

  assign is_data  = (op_q == OP_CONT) || (op_q == OP_TEXT) || (op_q == OP_BINARY);
  // key byte for this payload position, first key byte is the top one
  assign key_byte = mask_q ? key_q[{~pos_q, 3'b000} +: 8] : 8'h00;

  // Next-state and result logic
  always_comb begin
    phase_d     = phase_q;
    final_d     = final_q;
    op_d        = op_q;
    mask_d      = mask_q;
    len_d       = len_q;
    cnt_d       = cnt_q;
    long_d      = long_q;
    key_d       = key_q;
    pos_d       = pos_q;
    after_len   = 1'b0;
    hdr_done    = 1'b0;
    pay_end     = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;
    res_o.msg_type = op_q;

    case (phase_q)
      PH_HDR1: begin
        mask_d = byte_i[7];
        cnt_d  = 3'd0;
        if (byte_i[6:0] < LEN_EXT16) begin
          len_d     = LENGTH_WIDTH'(byte_i[6:0]);
          after_len = 1'b1;
        end else begin
          long_d  = (byte_i[6:0] == LEN_EXT64);
          len_d   = '0;
          phase_d = PH_EXT;
        end
      end
      PH_EXT: begin
        len_d = {len_q[LENGTH_WIDTH-9:0], byte_i};
        if (cnt_q >= (long_q ? 3'd7 : 3'd1)) begin
          after_len = 1'b1;
        end else begin
          cnt_d = cnt_q + 3'd1;
        end
      end
      PH_KEY: begin
        key_d = {key_q[23:0], byte_i};
        if (cnt_q >= 3'd3) begin
          hdr_done = 1'b1;
        end else begin
          cnt_d = cnt_q + 3'd1;
        end
      end
      PH_PAY: begin
        pos_d   = pos_q + 2'd1;
        len_d   = len_q - LENGTH_WIDTH'(1);
        pay_end = (len_d == '0);
        if (pay_end) begin
          phase_d = PH_HDR0;
        end
        if (is_data) begin
          res_valid_o       = 1'b1;
          res_o.data        = byte_i ^ key_byte;
          res_o.byte_valid  = 1'b1;
          res_o.frame_end   = pay_end;
          res_o.message_end = pay_end & final_q;
        end else if (pay_end) begin
          res_valid_o = 1'b1;
          res_o.drop  = 1'b1;
        end
      end
      default: begin
        final_d = byte_i[7];
        op_d    = byte_i[3:0];
        phase_d = PH_HDR1;
      end
    endcase

    // length known: key next, or header complete
    if (after_len) begin
      cnt_d = 3'd0;
      if (mask_d) begin
        phase_d = PH_KEY;
      end else begin
        hdr_done = 1'b1;
      end
    end

    // header complete: payload next, or close an empty frame
    if (hdr_done) begin
      pos_d = 2'd0;
      cnt_d = 3'd0;
      if (len_d != '0) begin
        phase_d = PH_PAY;
      end else begin
        phase_d     = PH_HDR0;
        res_valid_o = 1'b1;
        if (is_data) begin
          res_o.frame_end   = 1'b1;
          res_o.message_end = final_q;
        end else begin
          res_o.drop = 1'b1;
        end
      end
    end
  end

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HDR0;
      final_q <= 1'b0;
      op_q    <= '0;
      mask_q  <= 1'b0;
      len_q   <= '0;
      cnt_q   <= '0;
      long_q  <= 1'b0;
      key_q   <= '0;
      pos_q   <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      final_q <= final_d;
      op_q    <= op_d;
      mask_q  <= mask_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      long_q  <= long_d;
      key_q   <= key_d;
      pos_q   <= pos_d;
    end
  end

endmodule

/* hdl/wsdf_queue.sv */
// ----------------------------------------------------------------------------
// wsdf_queue
// Short result queue between parser and output stage.
// ----------------------------------------------------------------------------
module wsdf_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  wsdf_pkg::wsdf_res_t push_data_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                not_empty_o,
  output wsdf_pkg::wsdf_res_t pop_data_o
);
  import wsdf_pkg::*;

  wsdf_res_t           mem_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QUEUE_AW:0]   count_q, count_d;

  assign full_o      = (count_q == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign not_empty_o = (count_q != '0);
  assign pop_data_o  = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + (QUEUE_AW + 1)'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - (QUEUE_AW + 1)'(1);
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

endmodule

/* hdl/wsdf_back.sv */
// ----------------------------------------------------------------------------
// wsdf_back
// Output register: takes results from the queue and presents them on the
// output channel.
// ----------------------------------------------------------------------------
module wsdf_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_not_empty_i,
  input  wsdf_pkg::wsdf_res_t q_data_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output wsdf_pkg::wsdf_res_t out_res_o
);
  import wsdf_pkg::*;

  logic      valid_q;
  wsdf_res_t res_q;

  // load when the register is empty or being drained
  assign q_pop_o     = q_not_empty_i && (!valid_q || out_ready_i);
  assign out_valid_o = valid_q;
  assign out_res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!valid_q || out_ready_i) begin
      valid_q <= q_not_empty_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      res_q <= q_data_i;
    end
  end

endmodule

/* hdl/websocket_frame_deframer.sv */
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Parses a raw WebSocket byte stream into unmasked payload bytes with
// frame-end, message-end and drop marks.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+---------------------------
//   in      | input     | in_valid_i/in_ready_o   | in_byte_i
//   out     | output    | out_valid_o/out_ready_i | out_byte_o, byte_valid_o,
//           |           |                        | frame_end_o, message_end_o,
//           |           |                        | message_type_o, message_drop_o
//
// One input byte per cycle while the queue is not full; the parser handles
// each byte combinationally and pushes its result at the accepting edge.
// The output register then loads the result from the queue, so each
// result passes through queue and output register before it is offered.
// A two-entry queue sits between parser and output register; input ready
// drops only when that queue is full.
// Reset is asynchronous and clears parser state, queue and output valid.
// ----------------------------------------------------------------------------
module websocket_frame_deframer #(
  parameter int unsigned LENGTH_WIDTH = wsdf_pkg::LENGTH_WIDTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       frame_end_o,
  output logic       message_end_o,
  output logic [3:0] message_type_o,
  output logic       message_drop_o
);
  import wsdf_pkg::*;

  logic      accept;
  logic      res_valid;
  wsdf_res_t res;
  logic      q_full;
  logic      q_not_empty;
  logic      q_pop;
  wsdf_res_t q_data;
  wsdf_res_t out_res;

  assign in_ready_o = !q_full;
  assign accept     = in_valid_i && in_ready_o;

  wsdf_front #(
    .LENGTH_WIDTH(LENGTH_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .byte_i     (in_byte_i),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  wsdf_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (accept && res_valid),
    .push_data_i(res),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .not_empty_o(q_not_empty),
    .pop_data_o (q_data)
  );

  wsdf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_not_empty_i(q_not_empty),
    .q_data_i     (q_data),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_res_o    (out_res)
  );

  assign out_byte_o     = out_res.data;
  assign byte_valid_o   = out_res.byte_valid;
  assign frame_end_o    = out_res.frame_end;
  assign message_end_o  = out_res.message_end;
  assign message_type_o = out_res.msg_type;
  assign message_drop_o = out_res.drop;

endmodule

/* hdl/wsdf_checker.sv */
// ----------------------------------------------------------------------------
// wsdf_checker
// Port-level checks for the WebSocket frame deframer.
// ----------------------------------------------------------------------------
module wsdf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_byte_o,
  input logic       byte_valid_o,
  input logic       frame_end_o,
  input logic       message_end_o,
  input logic [3:0] message_type_o,
  input logic       message_drop_o
);

  // stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output transaction withdrawn while stalled");

  // end marks without data carry a zero byte
  a_zero_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !byte_valid_o |-> out_byte_o == 8'h00)
    else $error("non-data result carries a byte");

  // drop marks never close a data frame
  a_drop_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && message_drop_o |-> !frame_end_o && !message_end_o && !byte_valid_o)
    else $error("drop mark combined with data marks");

  // message end only on a frame end
  a_msg_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && message_end_o |-> frame_end_o)
    else $error("message end without frame end");

  // data bytes only come from data frames
  a_data_type: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && byte_valid_o |->
      (message_type_o == 4'h0) || (message_type_o == 4'h1) || (message_type_o == 4'h2))
    else $error("payload byte from a control frame");

endmodule

bind websocket_frame_deframer wsdf_checker u_wsdf_checker (.*);
